// ----- rtl/core/pideig_pkg.sv -----
// ----------------------------------------------------------------------------
// pideig_pkg
// Shared types, constants and fixed-point helpers for the power iteration
// eigenvalue core.
// ----------------------------------------------------------------------------
package pideig_pkg;

  localparam int unsigned MATRIX_SIZE_DEF   = 8;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned CFG_W             = 7;
  localparam int unsigned INDEX_W           = 4;
  localparam logic [CFG_W-1:0] ITER_RESET   = 7'd8;
  localparam logic [CFG_W-1:0] ITER_MAX     = 7'd64;

  // One matrix element as it arrives.
  typedef struct packed {
    logic signed [DATA_W-1:0] matrix_value;
    logic                     last_element;
  } in_item_t;

  // One eigenvalue as it leaves.
  typedef struct packed {
    logic signed [DATA_W-1:0] eigenvalue;
    logic [INDEX_W-1:0]       eigen_index;
    logic                     last_result;
    logic                     zero_norm;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_MULT,
    ST_DOT,
    ST_QUOT,
    ST_QWAIT,
    ST_SQRT,
    ST_SWAIT,
    ST_NREAD,
    ST_NSTART,
    ST_NWAIT,
    ST_ITEND,
    ST_DEFL,
    ST_EMIT
  } state_t;

  // Operations of the shared iterative unit.
  typedef enum logic {
    ARITH_DIV,
    ARITH_SQRT
  } arith_op_t;

  // Round a full product to f fraction bits, half up (floor of p + half).
  function automatic logic signed [63:0] fixed_round(input logic signed [63:0] p,
                                                     input int unsigned f);
    logic signed [63:0] half;
    half = 64'sd1 <<< (f - 1);
    return (p + half) >>> f;
  endfunction

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sh0000000080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Magnitude of a 32-bit signed value, exact for the most negative value.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Apply a sign to a magnitude and saturate to 32 bits.
  function automatic logic signed [31:0] with_sign(input logic [63:0] mag, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (mag > 64'h0000000080000000) begin
        r = 32'sh80000000;
      end else begin
        r = 32'(-mag);
      end
    end else begin
      if (mag > 64'h000000007FFFFFFF) begin
        r = 32'sh7FFFFFFF;
      end else begin
        r = mag[31:0];
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/pideig_ram.sv -----
// ----------------------------------------------------------------------------
// pideig_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module pideig_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/core/pideig_arith.sv -----
// ----------------------------------------------------------------------------
// pideig_arith
// Shared restoring unit: unsigned division one quotient bit per cycle, or
// floor square root one root bit per cycle.
// ----------------------------------------------------------------------------
module pideig_arith
  import pideig_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  arith_op_t   op,
  input  logic [63:0] operand,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] result
);

  // Dividends never exceed 32 + FRACTION_BITS bits.
  localparam int unsigned DIV_W  = 32 + FRACTION_BITS;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  arith_op_t          op_r;
  logic [63:0]        work;
  logic [65:0]        rem;
  logic [31:0]        den;
  logic [STEP_W-1:0]  steps;
  logic [65:0]        cand;
  logic [65:0]        trial;
  logic               ge;

  // Trial subtraction shared by both operations.
  always_comb begin
    if (op_r == ARITH_DIV) begin
      cand  = {rem[64:0], work[63]};
      trial = {34'd0, den};
    end else begin
      cand  = {rem[63:0], work[63:62]};
      trial = {result, 2'b01};
    end
    ge = (cand >= trial);
  end

  // Step sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= op;
      work   <= (op == ARITH_DIV) ? (operand << (64 - DIV_W)) : operand;
      rem    <= '0;
      result <= '0;
      den    <= divisor;
      steps  <= (op == ARITH_DIV) ? STEP_W'(DIV_W) : STEP_W'(32);
    end else if (busy) begin
      rem    <= ge ? (cand - trial) : cand;
      result <= {result[62:0], ge};
      work   <= (op_r == ARITH_DIV) ? (work << 1) : (work << 2);
      steps  <= steps - STEP_W'(1);
    end
  end

endmodule

// ----- rtl/core/power_iteration_deflation_eigen_core.sv -----
// ----------------------------------------------------------------------------
// power_iteration_deflation_eigen_core
// Loads a square fixed-point matrix, then finds its eigenvalues one by one by
// power iteration with deflation, emitting one eigenvalue per round.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  element   in         start & !busy         in_item_t (matrix_value, last_element)
//  result    out        done, one cycle       out_item_t (eigenvalue, index, flags)
//  cfg       in         cfg_valid & cfg_ready cfg_data (iteration count)
//
// An element is taken whenever start is high and busy is low; busy stays low while loading.
// After the last element, each of N rounds fills the vector, then per
// iteration runs the streaming passes, the quotient, the square root and
// normalization (the last three on the shared divider) and a closing
// state, then deflation and an emit state. A zero norm refills the vector
// with zeros in place of normalization.
// Reset is synchronous; memories are not cleared. The result is shown for
// exactly one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module power_iteration_deflation_eigen_core
  import pideig_pkg::*;
#(
  parameter int unsigned MATRIX_SIZE   = MATRIX_SIZE_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         element,
  output logic             done,
  output out_item_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned CELLS  = MATRIX_SIZE * MATRIX_SIZE;
  localparam int unsigned CELL_W = $clog2(CELLS);
  localparam int unsigned LOAD_W = $clog2(CELLS + 1);
  localparam int unsigned IDX_W  = $clog2(MATRIX_SIZE);
  localparam int unsigned VA_W   = $clog2(2 * MATRIX_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MATRIX_SIZE - 1);
  localparam logic [VA_W-1:0]  Y_BASE   = VA_W'(MATRIX_SIZE);

  state_t state, state_next;

  logic [CFG_W-1:0]  iter_cfg;
  logic [CFG_W-1:0]  iter_eff;
  logic [CFG_W-1:0]  iter_num;
  logic [LOAD_W-1:0] load_pos;
  logic [IDX_W-1:0]  round;
  logic [IDX_W-1:0]  si, sj;
  logic [CELL_W-1:0] maddr;
  logic              issue_done;
  logic              fill_ones;
  logic              zero_flag;
  logic              clear_ctr;
  logic              accept;
  logic              streaming;
  logic              stream_end;
  logic              iter_last;

  // Stream pipeline.
  logic              v1, v2, v3, v4;
  logic [IDX_W-1:0]  i1, i2;
  logic              last1, last2;
  logic [CELL_W-1:0] a1, a2, a3, a4;
  logic signed [63:0] p_a2, p_b2, p4;
  logic [63:0]        p_c2;
  logic signed [31:0] w2, w3, w4, o3;

  // Accumulators and per-iteration results.
  logic signed [63:0] acc_a, acc_b;
  logic [63:0]        ss;
  logic [64:0]        ss_sum;
  logic signed [63:0] mv_sum;
  logic signed [31:0] estimate;
  logic [31:0]        norm;
  logic               quot_neg, norm_neg;
  logic signed [31:0] dyx_s, dxx_s;

  // Memory ports.
  logic               mat_we;
  logic [CELL_W-1:0]  mat_waddr;
  logic [31:0]        mat_wdata, mat_rdata;
  logic               vec_we;
  logic [VA_W-1:0]    vec_waddr, vec_raddr_a, vec_raddr_b;
  logic [31:0]        vec_wdata, vec_rdata_a, vec_rdata_b;
  logic signed [31:0] xa, xb;

  // Shared divider and square root unit.
  logic               arith_start, arith_busy, arith_done;
  arith_op_t          arith_op;
  logic [63:0]        arith_operand, arith_result;
  logic [31:0]        arith_divisor;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign streaming = (state == ST_MULT) || (state == ST_DOT) || (state == ST_DEFL);
  assign stream_end = issue_done && !v1 && !v2 && !v3 && !v4;
  assign xa = $signed(vec_rdata_a);
  assign xb = $signed(vec_rdata_b);

  // Sum of squares, one bit wider to catch the carry for saturation.
  assign ss_sum = {1'b0, ss} + {1'b0, p_c2};

  // Effective iteration count, clamped into 1..64.
  always_comb begin
    if (iter_cfg == '0) begin
      iter_eff = CFG_W'(1);
    end else if (iter_cfg > ITER_MAX) begin
      iter_eff = ITER_MAX;
    end else begin
      iter_eff = iter_cfg;
    end
    iter_last = ((iter_num + CFG_W'(1)) == iter_eff);
  end

  // Saturated dot products for the Rayleigh quotient.
  assign dyx_s = sat32(acc_a);
  assign dxx_s = sat32(acc_b);

  // Operand selection for the shared unit.
  always_comb begin
    arith_operand = ss;
    arith_divisor = norm;
    if (state == ST_QUOT) begin
      arith_operand = ({32'd0, mag32(dyx_s)} << FRACTION_BITS) + {33'd0, dxx_s[31:1]};
      arith_divisor = dxx_s;
    end else if (state == ST_NSTART) begin
      arith_operand = ({32'd0, mag32(xb)} << FRACTION_BITS) + {33'd0, norm[31:1]};
    end
  end

  // Next state and strobes.
  always_comb begin
    state_next  = state;
    clear_ctr   = 1'b0;
    arith_start = 1'b0;
    arith_op    = ARITH_DIV;
    case (state)
      ST_IDLE: begin
        if (accept && element.last_element) begin
          clear_ctr  = 1'b1;
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (sj == IDX_LAST) begin
          clear_ctr  = 1'b1;
          state_next = fill_ones ? ST_MULT : ST_ITEND;
        end
      end
      ST_MULT: begin
        if (stream_end) begin
          clear_ctr  = 1'b1;
          state_next = ST_DOT;
        end
      end
      ST_DOT: begin
        if (stream_end) begin
          state_next = ST_QUOT;
        end
      end
      ST_QUOT: begin
        if (dxx_s <= 0) begin
          state_next = ST_SQRT;
        end else begin
          arith_start = 1'b1;
          state_next  = ST_QWAIT;
        end
      end
      ST_QWAIT: begin
        if (arith_done) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        arith_start = 1'b1;
        arith_op    = ARITH_SQRT;
        state_next  = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (arith_done) begin
          clear_ctr  = 1'b1;
          state_next = (arith_result[31:0] == '0) ? ST_FILL : ST_NREAD;
        end
      end
      ST_NREAD: begin
        state_next = ST_NSTART;
      end
      ST_NSTART: begin
        arith_start = 1'b1;
        state_next  = ST_NWAIT;
      end
      ST_NWAIT: begin
        if (arith_done) begin
          state_next = (si == IDX_LAST) ? ST_ITEND : ST_NREAD;
        end
      end
      ST_ITEND: begin
        clear_ctr  = 1'b1;
        state_next = iter_last ? ST_DEFL : ST_MULT;
      end
      ST_DEFL: begin
        if (stream_end) begin
          clear_ctr  = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        clear_ctr  = 1'b1;
        state_next = (round == IDX_LAST) ? ST_IDLE : ST_FILL;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Memory address and write selection.
  always_comb begin
    mat_we    = 1'b0;
    mat_waddr = a4;
    mat_wdata = sat32(64'(w4) - fixed_round(p4, FRACTION_BITS));
    if (accept) begin
      mat_we    = (load_pos < LOAD_W'(CELLS));
      mat_waddr = load_pos[CELL_W-1:0];
      mat_wdata = element.matrix_value;
    end else if (state == ST_DEFL) begin
      mat_we = v4;
    end

    mv_sum    = acc_a + fixed_round(p_a2, FRACTION_BITS);
    vec_we    = 1'b0;
    vec_waddr = VA_W'(sj);
    vec_wdata = fill_ones ? (32'd1 << FRACTION_BITS) : 32'd0;
    case (state)
      ST_FILL: begin
        vec_we = 1'b1;
      end
      ST_MULT: begin
        vec_we    = v2 && last2;
        vec_waddr = Y_BASE + VA_W'(i2);
        vec_wdata = sat32(mv_sum);
      end
      ST_NWAIT: begin
        vec_we    = arith_done;
        vec_waddr = VA_W'(si);
        vec_wdata = with_sign(arith_result, norm_neg);
      end
      default: begin
        vec_we = 1'b0;
      end
    endcase

    vec_raddr_a = VA_W'(sj);
    vec_raddr_b = Y_BASE + VA_W'(sj);
    case (state)
      ST_DEFL: begin
        vec_raddr_a = VA_W'(si);
        vec_raddr_b = VA_W'(sj);
      end
      ST_NREAD, ST_NSTART, ST_NWAIT: begin
        vec_raddr_b = Y_BASE + VA_W'(si);
      end
      default: begin
        vec_raddr_a = VA_W'(sj);
      end
    endcase
  end

  // Configuration, loading, counters and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      iter_cfg   <= ITER_RESET;
      load_pos   <= '0;
      round      <= '0;
      iter_num   <= '0;
      si         <= '0;
      sj         <= '0;
      maddr      <= '0;
      issue_done <= 1'b0;
      fill_ones  <= 1'b1;
      zero_flag  <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        iter_cfg <= cfg_data;
      end
      if (accept) begin
        if (element.last_element) begin
          load_pos <= '0;
        end else if (load_pos < LOAD_W'(CELLS)) begin
          load_pos <= load_pos + LOAD_W'(1);
        end
      end

      // Stream and loop counters.
      if (clear_ctr) begin
        si         <= '0;
        sj         <= '0;
        maddr      <= '0;
        issue_done <= 1'b0;
      end else if (streaming && !issue_done) begin
        maddr <= maddr + CELL_W'(1);
        if (state == ST_DOT) begin
          sj <= sj + IDX_W'(1);
          if (sj == IDX_LAST) begin
            issue_done <= 1'b1;
          end
        end else if (sj == IDX_LAST) begin
          sj <= '0;
          if (si == IDX_LAST) begin
            issue_done <= 1'b1;
          end else begin
            si <= si + IDX_W'(1);
          end
        end else begin
          sj <= sj + IDX_W'(1);
        end
      end else if (state == ST_FILL) begin
        sj <= sj + IDX_W'(1);
      end else if (state == ST_NWAIT && arith_done) begin
        si <= si + IDX_W'(1);
      end

      v1 <= streaming && !issue_done;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;

      // Round bookkeeping.
      case (state)
        ST_IDLE: begin
          if (accept && element.last_element) begin
            fill_ones <= 1'b1;
            round     <= '0;
            iter_num  <= '0;
            zero_flag <= 1'b0;
          end
        end
        ST_SWAIT: begin
          if (arith_done && arith_result[31:0] == '0) begin
            fill_ones <= 1'b0;
            zero_flag <= 1'b1;
          end
        end
        ST_ITEND: begin
          iter_num <= iter_num + CFG_W'(1);
        end
        ST_EMIT: begin
          fill_ones <= 1'b1;
          iter_num  <= '0;
          zero_flag <= 1'b0;
          round     <= (round == IDX_LAST) ? '0 : round + IDX_W'(1);
        end
        default: begin
          fill_ones <= fill_ones;
        end
      endcase

      done <= (state == ST_EMIT);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    i1    <= si;
    last1 <= (sj == IDX_LAST);
    a1    <= maddr;
    i2    <= i1;
    last2 <= last1;
    a2    <= a1;
    a3    <= a2;
    a4    <= a3;

    // Products p_a2, p_b2 and p_c2 are registered together and p4 later; the operands of p_a2 depend on the pass.
    p_a2 <= 64'((state == ST_MULT) ? $signed(mat_rdata) : xb) * 64'(xa);
    p_b2 <= 64'(xa) * 64'(xa);
    p_c2 <= {32'd0, mag32(xb)} * {32'd0, mag32(xb)};
    w2   <= $signed(mat_rdata);
    o3   <= sat32(fixed_round(p_a2, FRACTION_BITS));
    w3   <= w2;
    p4   <= 64'(estimate) * 64'(o3);
    w4   <= w3;

    // Accumulation of the streaming passes.
    if (clear_ctr) begin
      acc_a <= '0;
      acc_b <= '0;
      ss    <= '0;
    end else if (v2 && state == ST_MULT) begin
      acc_a <= last2 ? 64'sd0 : mv_sum;
    end else if (v2 && state == ST_DOT) begin
      acc_a <= mv_sum;
      acc_b <= acc_b + fixed_round(p_b2, FRACTION_BITS);
      ss    <= ss_sum[64] ? '1 : ss_sum[63:0];
    end

    // Quotient, norm and sign bookkeeping.
    if (state == ST_QUOT) begin
      quot_neg <= dyx_s[31];
      if (dxx_s <= 0) begin
        estimate <= '0;
      end
    end
    if (state == ST_QWAIT && arith_done) begin
      estimate <= with_sign(arith_result, quot_neg);
    end
    if (state == ST_SWAIT && arith_done) begin
      norm <= arith_result[31:0];
    end
    if (state == ST_NSTART) begin
      norm_neg <= xb[31];
    end

    // Result register.
    if (state == ST_EMIT) begin
      result.eigenvalue  <= estimate;
      result.eigen_index <= INDEX_W'(round);
      result.last_result <= (round == IDX_LAST);
      result.zero_norm   <= zero_flag;
    end
  end

  pideig_ram #(
    .WIDTH (32),
    .DEPTH (CELLS)
  ) u_matrix_ram (
    .clk     (clk),
    .we      (mat_we),
    .waddr   (mat_waddr),
    .wdata   (mat_wdata),
    .raddr_a (maddr),
    .rdata_a (mat_rdata),
    .raddr_b (maddr),
    .rdata_b ()
  );

  pideig_ram #(
    .WIDTH (32),
    .DEPTH (2 * MATRIX_SIZE)
  ) u_vector_ram (
    .clk     (clk),
    .we      (vec_we),
    .waddr   (vec_waddr),
    .wdata   (vec_wdata),
    .raddr_a (vec_raddr_a),
    .rdata_a (vec_rdata_a),
    .raddr_b (vec_raddr_b),
    .rdata_b (vec_rdata_b)
  );

  pideig_arith #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_arith (
    .clk     (clk),
    .rst     (rst),
    .start   (arith_start),
    .op      (arith_op),
    .operand (arith_operand),
    .divisor (arith_divisor),
    .busy    (arith_busy),
    .done    (arith_done),
    .result  (arith_result)
  );

  // The shared unit is never restarted while it works.
  assert property (@(posedge clk) disable iff (rst) arith_start |-> !arith_busy)
    else $error("arith unit started while busy");

  // The matrix is written only while loading or deflating.
  assert property (@(posedge clk) disable iff (rst)
      mat_we |-> (state == ST_IDLE || state == ST_DEFL))
    else $error("matrix write outside load or deflation");

  // After the final eigenvalue the core is ready for a new matrix.
  assert property (@(posedge clk) disable iff (rst) (done && result.last_result) |-> !busy)
    else $error("core still busy after final result");

endmodule
